[design/lcdw_pkg.sv]
package lcdw_pkg;

   // Request opcodes
   localparam logic [1:0] OP_TWO_DIGIT = 2'd0;
   localparam logic [1:0] OP_TENTHS    = 2'd1;
   localparam logic [1:0] OP_DECIMAL   = 2'd2;
   localparam logic [1:0] OP_NONE      = 2'd3;

   // LCD command and character codes
   localparam logic [7:0] CMD_LINE0   = 8'h80;
   localparam logic [7:0] CMD_LINE1   = 8'h90;
   localparam logic [7:0] CMD_FREQ    = 8'h91;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   localparam logic [7:0] LINE_SPLIT  = 8'd10;
   localparam logic [7:0] LINE1_BIAS  = 8'h86;   // 0x90 - 10, modulo 256

   localparam logic [16:0] MAX_TWO_DIGIT = 17'd99;
   localparam logic [16:0] MAX_TENTHS    = 17'd999;

   // Bit-serial binary to BCD converter
   localparam int BIN_WIDTH   = 16;
   localparam int DIGIT_COUNT = 5;
   localparam int STEP_WIDTH  = $clog2(BIN_WIDTH);

   typedef logic [DIGIT_COUNT-1:0][3:0] bcd_digits_type;

   typedef struct packed {
      logic                 start;
      logic [BIN_WIDTH-1:0] value;
   } bcd_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } bcd_stat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } seq_state_type;

endpackage

[design/lcdw_bcd.sv]
module lcdw_bcd (
   input  logic                    clock,
   input  logic                    reset,
   input  lcdw_pkg::bcd_ctrl_type  ctrl,
   output lcdw_pkg::bcd_stat_type  stat,
   output lcdw_pkg::bcd_digits_type digits
);

   logic [lcdw_pkg::BIN_WIDTH-1:0]  bin_ff, bin_in;
   lcdw_pkg::bcd_digits_type        bcd_ff, bcd_in;
   lcdw_pkg::bcd_digits_type        adj;
   logic [lcdw_pkg::DIGIT_COUNT*4-1:0] adj_bits;
   logic [lcdw_pkg::STEP_WIDTH-1:0] step_ff, step_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;

   // add 3 to every digit of five or more before the shift
   always_comb begin
      for (int k = 0; k < lcdw_pkg::DIGIT_COUNT; k++) begin
         adj[k] = (bcd_ff[k] >= 4'd5) ? bcd_ff[k] + 4'd3 : bcd_ff[k];
      end
   end

   assign adj_bits = adj;

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         bin_in  = ctrl.value;
         bcd_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bin_in  = {bin_ff[lcdw_pkg::BIN_WIDTH-2:0], 1'b0};
         bcd_in  = {adj_bits[lcdw_pkg::DIGIT_COUNT*4-2:0], bin_ff[lcdw_pkg::BIN_WIDTH-1]};
         step_in = step_ff + 1'b1;
         if (step_ff == lcdw_pkg::STEP_WIDTH'(lcdw_pkg::BIN_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign digits    = bcd_ff;

endmodule

[design/lcdw_seq.sv]
module lcdw_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [31:0]              req_tdata,
   input  logic [1:0]               req_tuser,
   output lcdw_pkg::bcd_ctrl_type   bcd_ctrl,
   input  lcdw_pkg::bcd_stat_type   bcd_stat,
   input  lcdw_pkg::bcd_digits_type bcd_digits,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,
   output logic                     rsp_tuser,
   output logic                     rsp_tlast
);

   lcdw_pkg::seq_state_type state_ff, state_in;
   logic [3:0]  idx_ff, idx_in;
   logic [1:0]  op_ff, op_in;
   logic        neg_ff, neg_in;
   logic [7:0]  pos_ff, pos_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [16:0] num;
   logic [7:0]  pos;
   logic [16:0] mag;
   logic        accept;
   logic        load;
   logic [2:0]  nd;
   logic [3:0]  sel_wide;
   logic [3:0]  digit;
   logic        wr_data;
   logic [7:0]  wr_byte;
   logic        wr_last;

   assign num    = req_tdata[16:0];
   assign pos    = req_tdata[24:17];
   assign mag    = num[16] ? (~num + 17'd1) : num;
   assign accept = req_tvalid && req_tready;

   // clamp the value for the converter for opcodes 0 and 1; opcode 2 passes the low 16 bits
   always_comb begin
      bcd_ctrl.start = accept && (req_tuser != lcdw_pkg::OP_NONE);
      unique case (req_tuser)
         lcdw_pkg::OP_TWO_DIGIT: begin
            if (num[16]) begin
               bcd_ctrl.value = '0;
            end else if (num > lcdw_pkg::MAX_TWO_DIGIT) begin
               bcd_ctrl.value = lcdw_pkg::MAX_TWO_DIGIT[15:0];
            end else begin
               bcd_ctrl.value = {9'd0, num[6:0]};
            end
         end
         lcdw_pkg::OP_TENTHS: begin
            bcd_ctrl.value = (mag > lcdw_pkg::MAX_TENTHS) ?
                             lcdw_pkg::MAX_TENTHS[15:0] : mag[15:0];
         end
         default: begin
            bcd_ctrl.value = num[15:0];
         end
      endcase
   end

   // significant digit count, at least one
   always_comb begin
      priority if (bcd_digits[4] != 4'd0) nd = 3'd5;
      else if (bcd_digits[3] != 4'd0)     nd = 3'd4;
      else if (bcd_digits[2] != 4'd0)     nd = 3'd3;
      else if (bcd_digits[1] != 4'd0)     nd = 3'd2;
      else                                nd = 3'd1;
   end

   assign sel_wide = {1'b0, nd} + 4'd7 - idx_ff;

   always_comb begin
      unique case (sel_wide)
         4'd0:    digit = bcd_digits[0];
         4'd1:    digit = bcd_digits[1];
         4'd2:    digit = bcd_digits[2];
         4'd3:    digit = bcd_digits[3];
         4'd4:    digit = bcd_digits[4];
         default: digit = 4'd0;
      endcase
   end

   // next write of the run
   always_comb begin
      wr_data = 1'b1;
      wr_byte = lcdw_pkg::CHAR_SPACE;
      wr_last = 1'b0;
      unique case (op_ff)
         lcdw_pkg::OP_TWO_DIGIT: begin
            unique case (idx_ff)
               4'd0: begin
                  wr_data = 1'b0;
                  wr_byte = (pos_ff < lcdw_pkg::LINE_SPLIT) ?
                            lcdw_pkg::CMD_LINE0 + pos_ff : lcdw_pkg::LINE1_BIAS + pos_ff;
               end
               4'd1: wr_byte = lcdw_pkg::CHAR_ZERO | {4'd0, bcd_digits[1]};
               default: begin
                  wr_byte = lcdw_pkg::CHAR_ZERO | {4'd0, bcd_digits[0]};
                  wr_last = 1'b1;
               end
            endcase
         end
         lcdw_pkg::OP_TENTHS: begin
            unique case (idx_ff)
               4'd0: begin
                  wr_data = 1'b0;
                  wr_byte = lcdw_pkg::CMD_LINE1;
               end
               4'd1: wr_byte = neg_ff ? lcdw_pkg::CHAR_MINUS : lcdw_pkg::CHAR_SPACE;
               4'd2: wr_byte = lcdw_pkg::CHAR_ZERO | {4'd0, bcd_digits[2]};
               4'd3: wr_byte = lcdw_pkg::CHAR_ZERO | {4'd0, bcd_digits[1]};
               4'd4: wr_byte = lcdw_pkg::CHAR_DOT;
               default: begin
                  wr_byte = lcdw_pkg::CHAR_ZERO | {4'd0, bcd_digits[0]};
                  wr_last = 1'b1;
               end
            endcase
         end
         default: begin
            priority if (idx_ff == 4'd0 || idx_ff == 4'd7) begin
               wr_data = 1'b0;
               wr_byte = lcdw_pkg::CMD_FREQ;
            end else if (idx_ff < 4'd7) begin
               wr_byte = lcdw_pkg::CHAR_SPACE;
            end else begin
               wr_byte = lcdw_pkg::CHAR_ZERO | {4'd0, digit};
               wr_last = (idx_ff == {1'b0, nd} + 4'd7);
            end
         end
      endcase
   end

   assign load = (state_ff == lcdw_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      op_in        = op_ff;
      neg_in       = neg_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         lcdw_pkg::ST_IDLE: begin
            // opcode three is taken and dropped
            if (bcd_ctrl.start) begin
               op_in    = req_tuser;
               neg_in   = num[16];
               pos_in   = pos;
               state_in = lcdw_pkg::ST_CONVERT;
            end
         end
         lcdw_pkg::ST_CONVERT: begin
            if (bcd_stat.done) begin
               idx_in   = '0;
               state_in = lcdw_pkg::ST_EMIT;
            end
         end
         default: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = wr_byte;
               rsp_data_in  = wr_data;
               rsp_last_in  = wr_last;
               idx_in       = idx_ff + 4'd1;
               if (wr_last) begin
                  state_in = lcdw_pkg::ST_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      op_ff       <= op_in;
      neg_ff      <= neg_in;
      pos_ff      <= pos_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= lcdw_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == lcdw_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[design/lcd_decimal_text_writer_top.sv]
// Character LCD text writer.
// The req channel takes one transaction per request: an opcode in tuser, a
// number and a position in tdata. The rsp channel gives the run of LCD bus
// writes it causes, one transaction per write: the byte in tdata, the
// command/data flag in tuser, tlast on the final write of the run.
// Runs are 3 writes (opcode 0), 6 writes (opcode 1) or 9 to 13 writes
// (opcode 2); opcode 3 is taken and produces nothing.
// Every request but opcode 3 goes through a bit-serial binary to BCD
// converter that shifts one bit per cycle over 16 bits. The first write of
// a run is presented after the conversion is done; the rest follow one per
// cycle while the receiver does not stall. req_tready rises again as soon
// as the last write sits in the output register.
// A receiver stall holds the output register and pauses the run; nothing is
// dropped. Reset (synchronous, active high) empties the output register and
// returns the block to idle with req_tready high.
module lcd_decimal_text_writer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [16:0] number, [24:17] position, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] lcd_byte
   output logic        rsp_tuser,   // [0] is_data
   output logic        rsp_tlast
);

   lcdw_pkg::bcd_ctrl_type   bcd_ctrl;
   lcdw_pkg::bcd_stat_type   bcd_stat;
   lcdw_pkg::bcd_digits_type bcd_digits;

   lcdw_bcd u_bcd (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (bcd_ctrl),
      .stat   (bcd_stat),
      .digits (bcd_digits)
   );

   lcdw_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .bcd_ctrl   (bcd_ctrl),
      .bcd_stat   (bcd_stat),
      .bcd_digits (bcd_digits),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef ASSERT_OFF
   a_idle_not_converting : assert property (
      @(posedge clock) disable iff (reset)
      req_tready |-> !bcd_stat.busy && !bcd_stat.done
   ) else $error("request taken while the converter is working");

   a_start_when_idle : assert property (
      @(posedge clock) disable iff (reset)
      bcd_ctrl.start |=> bcd_stat.busy && !req_tready
   ) else $error("converter start did not take");

   a_data_is_text : assert property (
      @(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_tdata == lcdw_pkg::CHAR_SPACE || rsp_tdata == lcdw_pkg::CHAR_MINUS ||
         rsp_tdata == lcdw_pkg::CHAR_DOT ||
         (rsp_tdata >= lcdw_pkg::CHAR_ZERO && rsp_tdata <= lcdw_pkg::CHAR_NINE)
   ) else $error("data write is not a display character");
`endif

endmodule
